/* rtl/core/ssim_pkg.sv */
// Shared constants and types for the sparse set index map.
package ssim_pkg;

   localparam int unsigned DEF_KEY_SPACE   = 1024;
   localparam int unsigned DEF_KIND_BITS   = 4;
   localparam int unsigned DEF_HANDLE_BITS = 32;

   typedef enum logic {
      CMD_ADD    = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

/* rtl/core/ssim_req_if.sv */
// Request channel: add/remove command with key, kind and handle.
interface ssim_req_if #(
   parameter int unsigned KEY_BITS    = 10,
   parameter int unsigned KIND_BITS   = 4,
   parameter int unsigned HANDLE_BITS = 32
);
   logic                   valid;
   logic                   ready;
   logic                   command;
   logic [KEY_BITS-1:0]    key;
   logic [KIND_BITS-1:0]   kind;
   logic [HANDLE_BITS-1:0] handle;

   modport source (output valid, command, key, kind, handle, input ready);
   modport sink   (input valid, command, key, kind, handle, output ready);
endinterface

/* rtl/core/ssim_rsp_if.sv */
// Response channel: accepted flag and live key count.
interface ssim_rsp_if #(
   parameter int unsigned CNT_BITS = 11
);
   logic                valid;
   logic                ready;
   logic                accepted;
   logic [CNT_BITS-1:0] live_count;

   modport source (output valid, accepted, live_count, input ready);
   modport sink   (input valid, accepted, live_count, output ready);
endinterface

/* rtl/core/ssim_slot_table.sv */
// Key-to-slot table: registered-read memory with clearing pass and a deferred clear write.
module ssim_slot_table #(
   parameter int unsigned KEY_SPACE = ssim_pkg::DEF_KEY_SPACE,
   localparam int unsigned KEY_BITS = $clog2(KEY_SPACE)
) (
   input  logic                clock,
   input  logic                reset,
   output logic                busy,
   input  logic                rd_en,
   input  logic [KEY_BITS-1:0] rd_addr,
   output logic [KEY_BITS:0]   rd_data,
   input  logic                wr_en,
   input  logic [KEY_BITS-1:0] wr_addr,
   input  logic [KEY_BITS:0]   wr_data,
   input  logic                def_en,
   input  logic [KEY_BITS-1:0] def_addr
);
   import ssim_pkg::*;

   localparam logic [KEY_BITS-1:0] LAST_KEY = KEY_BITS'(KEY_SPACE - 1);

   // entry = {present, slot}
   logic [KEY_BITS:0]   slot_mem [KEY_SPACE];
   logic [KEY_BITS:0]   rd_q_ff;
   logic                fwd_ff, fwd_in;
   logic                clr_busy_ff, clr_busy_in;
   logic [KEY_BITS-1:0] clr_idx_ff, clr_idx_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [KEY_BITS-1:0] pend_addr_ff, pend_addr_in;
   logic                mem_we;
   logic [KEY_BITS-1:0] mem_waddr;
   logic [KEY_BITS:0]   mem_wdata;

   // write port: clearing pass, then live write, then the deferred clear
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pend_addr_ff;
      mem_wdata = '0;
      priority if (clr_busy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_idx_ff;
      end else if (wr_en) begin
         mem_we    = 1'b1;
         mem_waddr = wr_addr;
         mem_wdata = wr_data;
      end else if (pend_valid_ff) begin
         mem_we    = 1'b1;
      end
   end

   always_comb begin
      clr_busy_in   = clr_busy_ff;
      clr_idx_in    = clr_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      fwd_in        = fwd_ff;
      if (clr_busy_ff) begin
         clr_idx_in  = clr_idx_ff + 1'b1;
         clr_busy_in = (clr_idx_ff != LAST_KEY);
      end
      if (pend_valid_ff && !clr_busy_ff && !wr_en) begin
         pend_valid_in = 1'b0;
      end
      if (def_en) begin
         pend_valid_in = 1'b1;
         pend_addr_in  = def_addr;
      end
      // read racing the deferred clear of the same key sees it absent
      if (rd_en) begin
         fwd_in = pend_valid_ff && (pend_addr_ff == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff   <= 1'b1;
         clr_idx_ff    <= '0;
         pend_valid_ff <= 1'b0;
         fwd_ff        <= 1'b0;
      end else begin
         clr_busy_ff   <= clr_busy_in;
         clr_idx_ff    <= clr_idx_in;
         pend_valid_ff <= pend_valid_in;
         fwd_ff        <= fwd_in;
      end
      pend_addr_ff <= pend_addr_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_q_ff <= slot_mem[rd_addr];
      end
   end

   assign rd_data = fwd_ff ? '0 : rd_q_ff;
   assign busy    = clr_busy_ff;

   a_pend_drains: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |=> !pend_valid_ff)
      else $error("deferred clear not drained");
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !rd_en && !wr_en && !def_en)
      else $error("table access during clearing pass");
   a_def_pair: assert property (@(posedge clock) disable iff (reset)
      def_en |-> wr_en && (wr_addr != def_addr))
      else $error("deferred clear without distinct moved-key write");

endmodule

/* rtl/core/sparse_set_index_map_unit.sv */
// Sparse set over a fixed key space: add/remove keys, dense list kept packed.
//
// Channels: req_ch carries command (add or remove), key, kind and handle;
// rsp_ch returns one transfer per request with the accepted flag and the
// number of live keys after that request. Both use valid/ready.
// Each request runs through an accept cycle and an execute state: the accept
// cycle reads the key's slot entry and the last dense key from their memories,
// and the execute state decides and writes back. The result is loaded into the
// output register when the execute state completes; a new request is taken in
// the cycle after the result is loaded, so no request overlaps the last one.
// A remove that moves the last dense entry writes the moved key's slot at
// once and clears the removed key's entry in the following cycle; a read that
// meets that pending clear is forwarded.
// Reset: synchronous. The slot table then runs a clearing pass over all
// KEY_SPACE entries (1024 by default) with req_ch.ready low.
// Stall: while a result waits with rsp_ch.ready low, the decided request
// holds in its execute cycle and no memory is written until it can go out.
module sparse_set_index_map_unit #(
   parameter int unsigned KEY_SPACE   = ssim_pkg::DEF_KEY_SPACE,
   parameter int unsigned KIND_BITS   = ssim_pkg::DEF_KIND_BITS,
   parameter int unsigned HANDLE_BITS = ssim_pkg::DEF_HANDLE_BITS
) (
   input logic     clock,
   input logic     reset,
   ssim_req_if.sink   req_ch,
   ssim_rsp_if.source rsp_ch
);
   import ssim_pkg::*;

   localparam int unsigned KEY_BITS = $clog2(KEY_SPACE);
   localparam int unsigned CNT_BITS = $clog2(KEY_SPACE + 1);
   localparam logic [KEY_BITS:0]   KEY_LIMIT = (KEY_BITS + 1)'(KEY_SPACE);
   localparam logic [CNT_BITS-1:0] CNT_LIMIT = CNT_BITS'(KEY_SPACE);

   state_type              state_ff, state_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   cmd_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [KIND_BITS-1:0]   kind_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic                   inrange_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_acc_ff;
   logic [CNT_BITS-1:0]    rsp_cnt_ff;
   logic [KEY_BITS-1:0]    last_key_ff;

   logic [KEY_BITS-1:0]    key_at_slot_mem [KEY_SPACE];
   logic [KIND_BITS-1:0]   kind_mem        [KEY_SPACE];
   logic [HANDLE_BITS-1:0] handle_mem      [KEY_SPACE];

   logic                   tbl_busy;
   logic [KEY_BITS:0]      slot_rd;
   logic                   slot_present;
   logic [KEY_BITS-1:0]    slot_idx;
   logic [CNT_BITS-1:0]    cnt_dec;
   logic                   req_fire, exec_fire;
   logic                   add_ok, rem_ok, do_move;
   logic                   tbl_wr_en, tbl_def_en;
   logic [KEY_BITS-1:0]    tbl_wr_addr;
   logic [KEY_BITS:0]      tbl_wr_data;
   logic                   ks_wr_en;
   logic [KEY_BITS-1:0]    ks_wr_addr, ks_wr_data;

   assign req_ch.ready = (state_ff == ST_IDLE) && !tbl_busy;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign exec_fire    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   assign slot_present = slot_rd[KEY_BITS];
   assign slot_idx     = slot_rd[KEY_BITS-1:0];
   assign cnt_dec      = count_ff - 1'b1;

   always_comb begin
      add_ok  = (cmd_ff == CMD_ADD) && inrange_ff && !slot_present && (count_ff < CNT_LIMIT);
      rem_ok  = (cmd_ff == CMD_REMOVE) && inrange_ff && slot_present && (count_ff != '0);
      do_move = rem_ok && (CNT_BITS'(slot_idx) < cnt_dec);
   end

   // slot table: add writes the new slot; a move rewrites the moved key and
   // defers clearing the removed key; a plain remove clears at once
   always_comb begin
      tbl_wr_en   = exec_fire && (add_ok || rem_ok);
      tbl_def_en  = exec_fire && do_move;
      tbl_wr_addr = do_move ? last_key_ff : key_ff;
      tbl_wr_data = '0;
      if (add_ok) begin
         tbl_wr_data = {1'b1, count_ff[KEY_BITS-1:0]};
      end else if (do_move) begin
         tbl_wr_data = {1'b1, slot_idx};
      end
      ks_wr_en   = exec_fire && (add_ok || do_move);
      ks_wr_addr = add_ok ? count_ff[KEY_BITS-1:0] : slot_idx;
      ks_wr_data = add_ok ? key_ff : last_key_ff;
   end

   ssim_slot_table #(
      .KEY_SPACE (KEY_SPACE)
   ) u_slot_table (
      .clock    (clock),
      .reset    (reset),
      .busy     (tbl_busy),
      .rd_en    (req_fire),
      .rd_addr  (req_ch.key),
      .rd_data  (slot_rd),
      .wr_en    (tbl_wr_en),
      .wr_addr  (tbl_wr_addr),
      .wr_data  (tbl_wr_data),
      .def_en   (tbl_def_en),
      .def_addr (key_ff)
   );

   always_ff @(posedge clock) begin
      if (ks_wr_en) begin
         key_at_slot_mem[ks_wr_addr] <= ks_wr_data;
      end
      if (req_fire) begin
         last_key_ff <= key_at_slot_mem[cnt_dec[KEY_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire && add_ok) begin
         kind_mem[key_ff]   <= kind_ff;
         handle_mem[key_ff] <= handle_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (add_ok) begin
                  count_in = count_ff + 1'b1;
               end else if (rem_ok) begin
                  count_in = cnt_dec;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         cmd_ff     <= req_ch.command;
         key_ff     <= req_ch.key;
         kind_ff    <= req_ch.kind;
         handle_ff  <= req_ch.handle;
         inrange_ff <= ({1'b0, req_ch.key} < KEY_LIMIT);
      end
      if (exec_fire) begin
         rsp_acc_ff <= add_ok || rem_ok;
         rsp_cnt_ff <= count_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.accepted   = rsp_acc_ff;
   assign rsp_ch.live_count = rsp_cnt_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_LIMIT)
      else $error("live count above key space");
   a_refused_holds: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && !(add_ok || rem_ok)) |=> count_ff == $past(count_ff))
      else $error("refused request changed the count");
   a_move_other: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && do_move) |-> last_key_ff != key_ff)
      else $error("moved key equals removed key");
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> rsp_valid_ff && (rsp_cnt_ff == count_ff))
      else $error("response count disagrees with live count");

endmodule

/* verif/tb_sparse_set_index_map_unit.sv */
// Self-checking testbench for the sparse set index map: random and directed add/remove traffic.
module tb_sparse_set_index_map_unit;
   import ssim_pkg::*;

   localparam int unsigned KEY_SPACE   = DEF_KEY_SPACE;
   localparam int unsigned KEY_BITS    = 10;
   localparam int unsigned CNT_BITS    = 11;
   localparam int          RUN_LIMIT   = 300000;
   localparam int          HOLD_AT     = 60;
   localparam int          HOLD_CYCLES = 400;

   typedef struct packed {
      cmd_type                    command;
      logic [KEY_BITS-1:0]        key;
      logic [DEF_KIND_BITS-1:0]   kind;
      logic [DEF_HANDLE_BITS-1:0] handle;
      logic                       drain_first;
   } set_op_type;

   typedef struct packed {
      logic                accepted;
      logic [CNT_BITS-1:0] live_count;
   } set_outcome_type;

   logic clock = 1'b0;
   logic reset;

   ssim_req_if #(
      .KEY_BITS   (KEY_BITS),
      .KIND_BITS  (DEF_KIND_BITS),
      .HANDLE_BITS(DEF_HANDLE_BITS)
   ) req_bus ();
   ssim_rsp_if #(.CNT_BITS(CNT_BITS)) rsp_bus ();

   sparse_set_index_map_unit dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus)
   );

   always #6 clock = ~clock;

   set_op_type      pending_q[$];
   set_outcome_type outcome_q[$];

   // predicted contents of the set
   bit                  live_bit[KEY_SPACE];
   logic [CNT_BITS-1:0] slot_at[KEY_SPACE];
   logic [KEY_BITS-1:0] dense_key[KEY_SPACE];
   logic [CNT_BITS-1:0] live_total = '0;

   // stimulus-side view of which keys are live, used to pick keys
   bit gen_in[KEY_SPACE];
   int gen_slot[KEY_SPACE];
   int gen_list[KEY_SPACE];
   int gen_n = 0;
   int order_q[$];

   int sent_cnt   = 0;
   int got_cnt    = 0;
   int gap_left   = 0;
   int stall_left = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;
   int quiet_from = 0;
   int cycle_cnt  = 0;
   bit failed     = 1'b0;

   function automatic set_outcome_type apply_set_op(set_op_type op);
      set_outcome_type     res;
      logic [CNT_BITS-1:0] hole;
      logic [KEY_BITS-1:0] last_key;
      res.accepted = 1'b0;
      if (op.command == CMD_ADD) begin
         if (!live_bit[op.key] && live_total < KEY_SPACE) begin
            live_bit[op.key]      = 1'b1;
            slot_at[op.key]       = live_total;
            dense_key[live_total] = op.key;
            live_total            = live_total + 1'b1;
            res.accepted          = 1'b1;
         end
      end else if (live_bit[op.key] && live_total != 0) begin
         hole             = slot_at[op.key];
         live_bit[op.key] = 1'b0;
         live_total       = live_total - 1'b1;
         // last dense entry fills the hole unless it was the one removed
         if (hole < live_total) begin
            last_key           = dense_key[live_total];
            dense_key[hole]    = last_key;
            slot_at[last_key]  = hole;
         end
         res.accepted = 1'b1;
      end
      res.live_count = live_total;
      return res;
   endfunction

   function automatic void queue_op(cmd_type cmd, int key, logic [DEF_KIND_BITS-1:0] kind,
                                    logic [DEF_HANDLE_BITS-1:0] handle, bit drain);
      set_op_type op;
      int         last;
      op.command     = cmd;
      op.key         = KEY_BITS'(key);
      op.kind        = kind;
      op.handle      = handle;
      op.drain_first = drain;
      pending_q.push_back(op);
      if (cmd == CMD_ADD && !gen_in[key]) begin
         gen_in[key]      = 1'b1;
         gen_slot[key]    = gen_n;
         gen_list[gen_n]  = key;
         gen_n++;
      end else if (cmd == CMD_REMOVE && gen_in[key]) begin
         gen_in[key] = 1'b0;
         gen_n--;
         last                     = gen_list[gen_n];
         gen_list[gen_slot[key]]  = last;
         gen_slot[last]           = gen_slot[key];
      end
   endfunction

   function automatic logic [DEF_KIND_BITS-1:0] rand_kind();
      return DEF_KIND_BITS'($urandom_range(0, (1 << DEF_KIND_BITS) - 1));
   endfunction

   function automatic int absent_key();
      int k;
      k = $urandom_range(0, KEY_SPACE - 1);
      while (gen_in[k] && gen_n < KEY_SPACE)
         k = $urandom_range(0, KEY_SPACE - 1);
      return k;
   endfunction

   function automatic int present_key();
      if (gen_n == 0)
         return $urandom_range(0, KEY_SPACE - 1);
      return gen_list[$urandom_range(0, gen_n - 1)];
   endfunction

   function automatic void shuffle_order();
      int j;
      int t;
      for (int i = order_q.size() - 1; i > 0; i--) begin
         j          = $urandom_range(0, i);
         t          = order_q[i];
         order_q[i] = order_q[j];
         order_q[j] = t;
      end
   endfunction

   // mostly well-formed traffic with random content; the rest is refused noise
   function automatic void queue_random(int count);
      int r;
      int k;
      int add_pct;
      add_pct = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0)
            add_pct = $urandom_range(35, 65);
         r = $urandom_range(0, 99);
         if (r < add_pct) begin
            queue_op(CMD_ADD, absent_key(), rand_kind(), $urandom(), i == 0);
         end else if (r < add_pct + 8) begin
            queue_op(CMD_ADD, present_key(), rand_kind(), $urandom(), i == 0);
         end else if (r < 90) begin
            queue_op(CMD_REMOVE, present_key(), rand_kind(), $urandom(), i == 0);
         end else if (r < 95) begin
            // add then remove the same key back to back
            k = absent_key();
            queue_op(CMD_ADD, k, rand_kind(), $urandom(), i == 0);
            queue_op(CMD_REMOVE, k, rand_kind(), $urandom(), 1'b0);
         end else begin
            queue_op(CMD_REMOVE, $urandom_range(0, KEY_SPACE - 1), rand_kind(),
                     $urandom(), i == 0);
         end
      end
   endfunction

   function automatic bit calm_window(int cnt);
      return cnt >= quiet_from || (cnt / 90) % 4 == 3;
   endfunction

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_ADD;
      req_bus.key        = '0;
      req_bus.kind       = '0;
      req_bus.handle     = '0;
      rsp_bus.ready      = 1'b0;

      // directed: empty set, extremes, refusals, moves and removal of the last entry
      queue_op(CMD_REMOVE, 0, 4'h0, 32'h0, 1'b0);
      queue_op(CMD_ADD, 0, 4'h0, 32'h0000_0000, 1'b0);
      queue_op(CMD_ADD, 0, 4'hF, 32'hFFFF_FFFF, 1'b0);
      queue_op(CMD_ADD, 1023, 4'hF, 32'hFFFF_FFFF, 1'b0);
      queue_op(CMD_ADD, 512, 4'h5, 32'hA5A5_A5A5, 1'b0);
      queue_op(CMD_REMOVE, 0, 4'h0, 32'h0, 1'b0);
      queue_op(CMD_REMOVE, 512, 4'h0, 32'h0, 1'b0);
      queue_op(CMD_REMOVE, 1023, 4'h0, 32'h0, 1'b0);
      queue_op(CMD_REMOVE, 1023, 4'hF, 32'hFFFF_FFFF, 1'b0);
      queue_op(CMD_ADD, 341, 4'hA, 32'h5555_5555, 1'b0);
      queue_op(CMD_ADD, 682, 4'h5, 32'hAAAA_AAAA, 1'b0);
      queue_op(CMD_REMOVE, 682, 4'h0, 32'h0, 1'b0);
      queue_op(CMD_ADD, 682, 4'h3, 32'h1234_5678, 1'b0);
      queue_op(CMD_REMOVE, 341, 4'h0, 32'h0, 1'b0);
      queue_op(CMD_REMOVE, 682, 4'h0, 32'h0, 1'b0);
      queue_op(CMD_ADD, 7, 4'h1, 32'h0000_0001, 1'b0);
      queue_op(CMD_REMOVE, 7, 4'h0, 32'h0, 1'b0);
      queue_op(CMD_ADD, 7, 4'h8, 32'h8000_0000, 1'b0);
      queue_op(CMD_ADD, 7, 4'h2, 32'h0000_0002, 1'b0);
      queue_op(CMD_REMOVE, 7, 4'h0, 32'h0, 1'b0);
      queue_op(CMD_REMOVE, 0, 4'h0, 32'h0, 1'b0);

      queue_random(200);

      // burst of fresh keys, then drain every live key in random order
      for (int i = 0; i < 60; i++)
         queue_op(CMD_ADD, absent_key(), rand_kind(), $urandom(), i == 0);
      order_q.delete();
      for (int i = 0; i < gen_n; i++)
         order_q.push_back(gen_list[i]);
      shuffle_order();
      foreach (order_q[i])
         queue_op(CMD_REMOVE, order_q[i], rand_kind(), $urandom(), 1'b0);
      queue_op(CMD_REMOVE, $urandom_range(0, KEY_SPACE - 1), rand_kind(), $urandom(), 1'b0);

      queue_random(200);
      quiet_from = pending_q.size() - 150;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || outcome_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (failed == 1'b0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin : req_driver
      set_op_type op;
      logic       offer;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         offer = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            op = pending_q.pop_front();
            outcome_q.push_back(apply_set_op(op));
            sent_cnt <= sent_cnt + 1;
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_q.size() != 0 &&
                         !(pending_q[0].drain_first && outcome_q.size() != 0)) begin
               if (!calm_window(sent_cnt) && $urandom_range(0, 4) == 0) begin
                  gap_left = $urandom_range(0, 7);
               end else begin
                  op = pending_q[0];
                  req_bus.command <= op.command;
                  req_bus.key     <= op.key;
                  req_bus.kind    <= op.kind;
                  req_bus.handle  <= op.handle;
                  offer = 1'b1;
               end
            end
         end
         req_bus.valid <= offer;
      end
   end

   // long receiver hold-off so the block backs up into the request side
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && sent_cnt >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      set_outcome_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_cnt <= got_cnt + 1;
            if (outcome_q.size() == 0) begin
               $error("unexpected transfer: accepted %0d, live_count %0d",
                      rsp_bus.accepted, rsp_bus.live_count);
               failed = 1'b1;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_bus.accepted !== want.accepted) begin
                  $error("accepted: expected %0d, got %0d", want.accepted, rsp_bus.accepted);
                  failed = 1'b1;
               end
               if (rsp_bus.live_count !== want.live_count) begin
                  $error("live_count: expected %0d, got %0d",
                         want.live_count, rsp_bus.live_count);
                  failed = 1'b1;
               end
            end
         end
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm_window(got_cnt) && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= RUN_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
